@@ rtl/clamped_moving_average_macros.svh @@
// ----------------------------------------------------------------------------
// Clamped moving average: assertion macros
// Shared concurrent assertion forms for the clamped moving average RTL.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_MOVING_AVERAGE_MACROS_SVH
`define CLAMPED_MOVING_AVERAGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clamped moving average: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clamped moving average: assertion failed");

`endif

@@ rtl/cma_pkg.sv @@
// ----------------------------------------------------------------------------
// Clamped moving average package
// Register indexes, field widths, reset values and shared types.
// ----------------------------------------------------------------------------
package cma_pkg;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_LIMIT  = 2'd2;

   // Fixed field widths.
   localparam int WINDOW_SIZE_BITS = 7;
   localparam int LIMIT_BITS       = 16;
   localparam int RING_BITS        = 16;
   localparam int AVG_BITS         = 16;
   localparam int CHANNEL_BITS     = 3;

   // Register reset values.
   localparam logic [WINDOW_SIZE_BITS-1:0] WINDOW_SIZE_RESET = 7'd8;
   localparam logic [LIMIT_BITS-1:0]       LOW_LIMIT_RESET   = 16'h8000;
   localparam logic [LIMIT_BITS-1:0]       HIGH_LIMIT_RESET  = 16'h7FFF;

   // Parameter defaults.
   localparam int CHANNELS_DEFAULT    = 8;
   localparam int WINDOW_MAX_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Status of the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ rtl/cma_div.sv @@
// ----------------------------------------------------------------------------
// Clamped moving average: serial divider
// Signed dividend by unsigned divisor, restoring, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`include "clamped_moving_average_macros.svh"

module cma_div #(
   parameter int SUM_BITS = 23,
   parameter int WS_BITS  = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [SUM_BITS-1:0]          dividend,
   input  logic        [WS_BITS-1:0]           divisor,
   output cma_pkg::div_stat_type               stat,
   output logic signed [cma_pkg::AVG_BITS-1:0] quotient
);
   import cma_pkg::*;

   localparam int CNT_BITS = $clog2(SUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WS_BITS-1:0]  rem_ff, rem_in;
   logic [SUM_BITS-1:0] quo_ff, quo_in;
   logic [WS_BITS-1:0]  dvs_ff, dvs_in;
   logic                neg_ff, neg_in;

   logic [WS_BITS:0]    shifted;
   logic [WS_BITS:0]    diff;
   logic                fits;
   logic [SUM_BITS-1:0] quo_signed;

   assign shifted = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         // The magnitude of the most negative sum still fits unsigned.
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(SUM_BITS);
         rem_in  = '0;
         quo_in  = dividend[SUM_BITS-1] ? (SUM_BITS'(0) - dividend) : dividend;
         dvs_in  = divisor;
         neg_in  = dividend[SUM_BITS-1];
      end else if (busy_ff) begin
         rem_in = fits ? diff[WS_BITS-1:0] : shifted[WS_BITS-1:0];
         quo_in = {quo_ff[SUM_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign quo_signed = neg_ff ? (SUM_BITS'(0) - quo_ff) : quo_ff;
   assign quotient   = quo_signed[AVG_BITS-1:0];
   assign stat.busy  = busy_ff;
   assign stat.done  = done_ff;

   `CMA_ASSERT_NEXT(a_start_makes_busy, clock, reset, start, busy_ff)
   `CMA_ASSERT_NOW(a_done_after_busy, clock, reset, done_ff, !busy_ff && !$past(done_ff))
   `CMA_ASSERT_NOW(a_busy_has_bits_left, clock, reset, busy_ff, cnt_ff != '0)

endmodule

@@ rtl/clamped_moving_average.sv @@
// ----------------------------------------------------------------------------
// Clamped moving average
// Per-channel ring of clamped samples with a running sum and a serial divide
// by the window size.
// ----------------------------------------------------------------------------
// Each accepted sample has its old ring entry read and the new entry written;
// when the channel was last updated under the same window size the sum is updated
// at once, otherwise the ring is summed again, one entry per cycle, first.
// One transaction is in flight at a time: no new sample is taken until the result
// from the one-bit-per-cycle divider has been handed out. After reset the ring is
// cleared one entry per cycle, CHANNELS x padded depth (512 by default), with req_stall high.
`include "clamped_moving_average_macros.svh"

module clamped_moving_average #(
   parameter int CHANNELS    = cma_pkg::CHANNELS_DEFAULT,
   parameter int WINDOW_MAX  = cma_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cma_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cma_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cma_pkg::CHANNEL_BITS-1:0]    req_channel,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cma_pkg::AVG_BITS-1:0] rsp_average
);
   import cma_pkg::*;

   localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_BITS  = $clog2(WINDOW_MAX);
   localparam int WS_BITS   = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS  = RING_BITS + $clog2(WINDOW_MAX) + 1;
   localparam int ADDR_BITS = CH_BITS + IDX_BITS;
   localparam int MEM_DEPTH = CHANNELS * (1 << IDX_BITS);
   localparam int CH_CODES  = 1 << CHANNEL_BITS;
   localparam int CMP_BITS  = (WINDOW_SIZE_BITS > WS_BITS) ? WINDOW_SIZE_BITS : WS_BITS;
   localparam int XB        = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_OLD   = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_TAIL  = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]                   state_ff, state_in;
   logic [ADDR_BITS-1:0]         clear_cnt_ff, clear_cnt_in;
   logic [WINDOW_SIZE_BITS-1:0]  window_size_ff;
   logic signed [LIMIT_BITS-1:0] low_ff, high_ff;

   logic [IDX_BITS-1:0]          windex_ff [CHANNELS];
   logic [WS_BITS-1:0]           tag_ff    [CHANNELS];
   logic signed [SUM_BITS-1:0]   sum_ff    [CHANNELS];

   logic [CH_BITS-1:0]           ch_ff, ch_in;
   logic signed [RING_BITS-1:0]  x_ff, x_in;
   logic [IDX_BITS-1:0]          idx_ff, idx_in;
   logic [WS_BITS-1:0]           ws_ff, ws_in;
   logic [IDX_BITS-1:0]          cnt_ff, cnt_in;
   logic signed [SUM_BITS-1:0]   acc_ff, acc_in;
   logic                         scan_valid_ff, scan_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [AVG_BITS-1:0]   avg_ff, avg_in;

   logic signed [RING_BITS-1:0]  mem [MEM_DEPTH];
   logic signed [RING_BITS-1:0]  rd_data_ff;
   logic [ADDR_BITS-1:0]         rd_addr, wr_addr;
   logic                         mem_we;
   logic signed [RING_BITS-1:0]  mem_wdata;

   logic [CH_BITS-1:0]           ch_sel;
   logic [CMP_BITS-1:0]          ws_wide;
   logic [WS_BITS-1:0]           ws_eff;
   logic [IDX_BITS-1:0]          idx_raw, idx_fix, idx_next;
   logic signed [XB-1:0]         samp_w, low_w, high_w, raised, clamped;
   logic signed [SUM_BITS-1:0]   sum_new;
   logic                         sum_we;
   logic                         incremental;
   logic                         accept;
   logic                         out_free;

   logic                         div_start;
   div_stat_type                 div_stat;
   logic signed [AVG_BITS-1:0]   div_quotient;

   // Channel numbers fold onto the channels that exist.
   always_comb begin
      ch_sel = '0;
      for (int k = 0; k < CH_CODES; k++) begin
         if (req_channel == CHANNEL_BITS'(k)) begin
            ch_sel = CH_BITS'(k % CHANNELS);
         end
      end
   end

   // A zero window counts as one; a window above the ring depth is capped.
   always_comb begin
      ws_wide = CMP_BITS'(window_size_ff);
      if (ws_wide == '0) begin
         ws_eff = WS_BITS'(1);
      end else if (ws_wide > CMP_BITS'(WINDOW_MAX)) begin
         ws_eff = WS_BITS'(WINDOW_MAX);
      end else begin
         ws_eff = ws_wide[WS_BITS-1:0];
      end
   end

   // The high limit is applied last, so it wins when the limits cross.
   assign samp_w  = XB'(req_sample);
   assign low_w   = XB'(low_ff);
   assign high_w  = XB'(high_ff);
   assign raised  = (samp_w < low_w) ? low_w : samp_w;
   assign clamped = (raised > high_w) ? high_w : raised;

   assign idx_raw  = windex_ff[ch_sel];
   assign idx_fix  = (WS_BITS'(idx_raw) >= ws_eff) ? '0 : idx_raw;
   assign idx_next = (WS_BITS'(idx_ff) >= (ws_ff - WS_BITS'(1))) ? '0
                                                                 : idx_ff + IDX_BITS'(1);

   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign incremental = (tag_ff[ch_ff] == ws_ff);

   always_comb begin
      state_in      = state_ff;
      clear_cnt_in  = clear_cnt_ff;
      ch_in         = ch_ff;
      x_in          = x_ff;
      idx_in        = idx_ff;
      ws_in         = ws_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      scan_valid_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      avg_in        = avg_ff;
      rd_addr       = {ch_ff, cnt_ff};
      wr_addr       = {ch_ff, idx_ff};
      mem_we        = 1'b0;
      mem_wdata     = x_ff;
      sum_new       = acc_ff + SUM_BITS'(rd_data_ff);
      sum_we        = 1'b0;
      div_start     = 1'b0;

      // Reads are registered, so the scan adds the entry read in the cycle before.
      if (scan_valid_ff) begin
         acc_in = acc_ff + SUM_BITS'(rd_data_ff);
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_addr      = clear_cnt_ff;
            mem_we       = 1'b1;
            mem_wdata    = '0;
            clear_cnt_in = clear_cnt_ff + ADDR_BITS'(1);
            if (clear_cnt_ff == ADDR_BITS'(MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               ch_in    = ch_sel;
               x_in     = clamped[RING_BITS-1:0];
               idx_in   = idx_fix;
               ws_in    = ws_eff;
               state_in = S_OLD;
            end
         end
         S_OLD: begin
            rd_addr  = {ch_ff, idx_ff};
            state_in = S_WRITE;
         end
         S_WRITE: begin
            mem_we = 1'b1;
            if (incremental) begin
               sum_new   = sum_ff[ch_ff] - SUM_BITS'(rd_data_ff) + SUM_BITS'(x_ff);
               sum_we    = 1'b1;
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               acc_in   = '0;
               cnt_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            scan_valid_in = 1'b1;
            cnt_in        = cnt_ff + IDX_BITS'(1);
            if (WS_BITS'(cnt_ff) == (ws_ff - WS_BITS'(1))) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            sum_we    = 1'b1;
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               avg_in       = div_quotient;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clear_cnt_ff   <= '0;
         window_size_ff <= WINDOW_SIZE_RESET;
         low_ff         <= LOW_LIMIT_RESET;
         high_ff        <= HIGH_LIMIT_RESET;
         scan_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            windex_ff[c] <= '0;
            tag_ff[c]    <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clear_cnt_ff  <= clear_cnt_in;
         scan_valid_ff <= scan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[WINDOW_SIZE_BITS-1:0];
               CSR_LOW_LIMIT:   low_ff         <= csr_wdata[LIMIT_BITS-1:0];
               CSR_HIGH_LIMIT:  high_ff        <= csr_wdata[LIMIT_BITS-1:0];
               default:         ;
            endcase
         end
         if (state_ff == S_WRITE) begin
            windex_ff[ch_ff] <= idx_next;
         end
         // A tag of zero matches no window, so the first update rescans.
         if (sum_we) begin
            tag_ff[ch_ff] <= ws_ff;
         end
      end
      if (sum_we) begin
         sum_ff[ch_ff] <= sum_new;
      end
      ch_ff  <= ch_in;
      x_ff   <= x_in;
      idx_ff <= idx_in;
      ws_ff  <= ws_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      avg_ff <= avg_in;
   end

   // Ring memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   cma_div #(
      .SUM_BITS (SUM_BITS),
      .WS_BITS  (WS_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (ws_ff),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = avg_ff;

   `CMA_ASSERT_NEXT(a_accept_reads_old, clock, reset, accept, state_ff == S_OLD)
   `CMA_ASSERT_NOW(a_index_in_window, clock, reset, state_ff == S_WRITE, WS_BITS'(idx_ff) < ws_ff)
   `CMA_ASSERT_NOW(a_start_divider_idle, clock, reset, div_start, !div_stat.busy)

endmodule

@@ verif/cma_average_checker.sv @@
// ----------------------------------------------------------------------------
// Clamped moving average checker
// Watches the register port and the request and result sides of the block, keeps its own
// copy of the per-channel rings and registers, predicts the average of every
// accepted sample and compares each returned average, in order, against it.
// ----------------------------------------------------------------------------
module cma_average_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [cma_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cma_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [cma_pkg::CHANNEL_BITS-1:0]    req_channel,
   input  logic signed [15:0]                  req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [cma_pkg::AVG_BITS-1:0] rsp_average,
   output int                                  pending,
   output int                                  fail_count,
   output int                                  results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CHANNELS = 8;
   localparam int RING_DEPTH   = 64;

   logic [cma_pkg::WINDOW_SIZE_BITS-1:0] win_reg;
   logic signed [cma_pkg::LIMIT_BITS-1:0] lo_reg;
   logic signed [cma_pkg::LIMIT_BITS-1:0] hi_reg;

   logic signed [cma_pkg::RING_BITS-1:0] slot_ring [NUM_CHANNELS][RING_DEPTH];
   int                                   next_slot [NUM_CHANNELS];

   logic signed [cma_pkg::AVG_BITS-1:0] pending_averages [$];
   logic signed [cma_pkg::AVG_BITS-1:0] want_average;

   initial begin
      pending = 0;
      fail_count = 0;
      results_checked = 0;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] average check: %s", $realtime, msg);
   endtask

   // Clamps the sample, stores it in the channel's ring and returns the
   // truncated mean of the entries inside the current window.
   function automatic logic signed [15:0] predict_average(input logic [2:0] ch,
                                                          input logic signed [15:0] smp);
      int                   span;
      int                   slot;
      int                   total;
      logic signed [15:0]   clamped;
      span = win_reg;
      if (span == 0) span = 1;
      if (span > RING_DEPTH) span = RING_DEPTH;
      clamped = smp;
      if (clamped < lo_reg) clamped = lo_reg;
      if (clamped > hi_reg) clamped = hi_reg;
      // After the window shrank, a stale index restarts the ring at entry zero.
      slot = next_slot[ch];
      if (slot >= span) slot = 0;
      slot_ring[ch][slot] = clamped;
      next_slot[ch] = (slot >= span - 1) ? 0 : slot + 1;
      total = 0;
      for (int i = 0; i < span; i++) total += slot_ring[ch][i];
      return 16'(total / span);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         win_reg = cma_pkg::WINDOW_SIZE_RESET;
         lo_reg = cma_pkg::LOW_LIMIT_RESET;
         hi_reg = cma_pkg::HIGH_LIMIT_RESET;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            next_slot[c] = 0;
            for (int i = 0; i < RING_DEPTH; i++) slot_ring[c][i] = '0;
         end
         pending_averages.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               cma_pkg::CSR_WINDOW_SIZE: win_reg = csr_wdata[cma_pkg::WINDOW_SIZE_BITS-1:0];
               cma_pkg::CSR_LOW_LIMIT:   lo_reg = csr_wdata;
               cma_pkg::CSR_HIGH_LIMIT:  hi_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pending_averages.push_back(predict_average(req_channel, req_sample));
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (pending_averages.size() == 0) begin
               report_mismatch($sformatf("average %0d returned with no transaction outstanding",
                                         rsp_average));
            end else begin
               want_average = pending_averages.pop_front();
               if (rsp_average !== want_average)
                  report_mismatch($sformatf("average got %0d, wanted %0d",
                                            rsp_average, want_average));
            end
         end
      end
      pending <= pending_averages.size();
   end

endmodule

@@ verif/clamped_moving_average_tb.sv @@
// ----------------------------------------------------------------------------
// Clamped moving average testbench
// Drives directed and random samples over all channels through a series of
// window and clamp settings, with random idle bursts on both the request and result
// sides, and takes its verdict from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module clamped_moving_average_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cma_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT   = 800_000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 125;
   localparam int DRAIN_LIMIT   = 2000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_we = 1'b0;
   logic [cma_pkg::CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [cma_pkg::CSR_DATA_BITS-1:0]   csr_wdata = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [cma_pkg::CHANNEL_BITS-1:0]    req_channel = '0;
   logic signed [15:0]                  req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [cma_pkg::AVG_BITS-1:0] rsp_average;

   int pending;
   int fail_count;
   int results_checked;

   int  cycle_count = 0;
   int  idle_pct = 0;
   bit  quiet = 1'b0;
   int  stall_left = 0;
   int  samples_sent = 0;
   int  settings_used = 0;
   logic signed [15:0] cur_lo = 16'sh8000;
   logic signed [15:0] cur_hi = 16'sh7FFF;

   clamped_moving_average dut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average)
   );

   cma_average_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_average     (rsp_average),
      .pending         (pending),
      .fail_count      (fail_count),
      .results_checked (results_checked)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d averages outstanding",
                  cycle_count, pending);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side back-pressure in random bursts of stalled cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(99) < idle_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(12, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_sample(input logic [2:0] ch, input logic signed [15:0] smp);
      int gap;
      if (!quiet && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(13, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel <= ch;
      req_sample <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   // Ends a phase: stop sending and wait until every average is back or DRAIN_LIMIT runs out.
   task automatic drain_phase();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
   endtask

   // Writes all three registers back to back; the window write carries
   // random upper bits that the block must ignore.
   task automatic apply_config(input logic [6:0] win, input logic signed [15:0] lo,
                               input logic signed [15:0] hi);
      csr_we <= 1'b1;
      csr_index <= cma_pkg::CSR_WINDOW_SIZE;
      csr_wdata <= {9'($urandom), win};
      @(posedge clock);
      csr_index <= cma_pkg::CSR_LOW_LIMIT;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= cma_pkg::CSR_HIGH_LIMIT;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_lo = lo;
      cur_hi = hi;
      settings_used++;
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'(int'(cur_lo) + int'($urandom_range(4)) - 2);
         3:       return 16'(int'(cur_hi) + int'($urandom_range(4)) - 2);
         4:       return 16'(int'($urandom_range(511)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [6:0]         win;
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      logic [2:0]         ch;
      logic [2:0]         last_ch;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // The block clears its ring memory after reset with req_stall high.
      @(posedge clock);
      while (req_stall) @(posedge clock);

      // Directed part, first at the reset register values.
      idle_pct = 20;
      send_sample(3'd0, 16'sh7FFF);
      send_sample(3'd0, 16'sh7FFF);
      send_sample(3'd7, 16'sh8000);
      send_sample(3'd3, 16'sh0000);
      send_sample(3'd3, 16'shFFFF);
      send_sample(3'd3, 16'sh0001);
      send_sample(3'd5, 16'sh0100);
      drain_phase();

      // Widest window; channel 2 runs its index well past the next window.
      apply_config(7'd64, 16'sh8000, 16'sh7FFF);
      for (int i = 0; i < 9; i++) send_sample(3'd2, 16'($urandom));
      send_sample(3'd1, 16'sh8000);
      drain_phase();

      // Shrunk window with tight limits on both sides.
      apply_config(7'd3, -16'sd256, 16'sd256);
      send_sample(3'd2, 16'sh7FFF);
      send_sample(3'd2, 16'sh8000);
      send_sample(3'd4, 16'sd100);
      drain_phase();

      // Zero window acts as one; crossed limits leave the high limit.
      apply_config(7'd0, 16'sd500, -16'sd500);
      send_sample(3'd6, 16'sh0000);
      send_sample(3'd6, 16'sh7FFF);
      drain_phase();

      // Oversized window acts as the largest; the spare index is ignored.
      apply_config(7'd127, 16'sh8000, 16'sh7FFF);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      send_sample(3'd6, 16'sh8000);
      send_sample(3'd0, 16'sh8000);
      drain_phase();

      // Random part: a new setting and idle profile for every phase.
      last_ch = '0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(7))
            0:       win = 7'd0;
            1:       win = 7'd1;
            2:       win = 7'd64;
            3:       win = 7'($urandom_range(127, 65));
            4, 5:    win = 7'($urandom_range(8, 2));
            default: win = 7'($urandom_range(63, 1));
         endcase
         case ($urandom_range(4))
            0: begin
               lo = 16'sh8000;
               hi = 16'sh7FFF;
            end
            1: begin
               lo = 16'($urandom);
               hi = 16'($urandom);
            end
            2: begin
               lo = 16'(-int'($urandom_range(8000)));
               hi = 16'($urandom_range(8000));
            end
            3: begin
               hi = 16'(-int'($urandom_range(4000)));
               lo = 16'(int'(hi) + 1 + int'($urandom_range(4000)));
            end
            default: begin
               lo = 16'($urandom);
               hi = lo;
            end
         endcase
         apply_config(win, lo, hi);
         case ($urandom_range(3))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            2:       idle_pct = 30;
            default: idle_pct = 60;
         endcase
         quiet = (ph == RANDOM_PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            ch = ($urandom_range(3) == 0) ? last_ch : 3'($urandom_range(7));
            send_sample(ch, pick_sample());
            last_ch = ch;
         end
         drain_phase();
      end

      // Tail: leave room for any stray average beyond the last one expected.
      repeat (100) @(posedge clock);
      $display("Sent %0d samples over %0d window and clamp settings, %0d averages checked",
               samples_sent, settings_used, results_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d averages never returned", fail_count, pending);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
